// File: hdl/fpba_pkg.sv
// ---------------------------------------------------------------------------
// Fit policy block allocator package
// Shared types, field widths and codes for the allocator and its parts.
// ---------------------------------------------------------------------------
package fpba_pkg;

   localparam int AMOUNT_W   = 16;
   localparam int BLK_IDX_W  = 4;
   localparam int REQ_NUM_W  = 16;
   localparam int POLICY_W   = 2;

   typedef logic [POLICY_W-1:0] policy_type;

   localparam policy_type POLICY_FIRST = 2'd0;
   localparam policy_type POLICY_BEST  = 2'd1;
   localparam policy_type POLICY_WORST = 2'd2;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_ALLOC = 1'b1;

   // Per-candidate control handed to the shared comparator
   typedef struct packed {
      logic       found;
      logic       taken;
      policy_type policy;
   } cmp_ctl_type;

endpackage

// File: hdl/fpba_size_ram.sv
// ---------------------------------------------------------------------------
// Block size table
// One write port and one registered read port holding loaded block sizes.
// ---------------------------------------------------------------------------
module fpba_size_ram #(
   parameter int DEPTH  = 16,
   parameter int WIDTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/fpba_fit_cmp.sv
// ---------------------------------------------------------------------------
// Fit comparator
// Decides whether one table entry qualifies and beats the current pick.
// ---------------------------------------------------------------------------
module fpba_fit_cmp #(
   parameter int SIZE_WIDTH = 16
) (
   input  logic [SIZE_WIDTH-1:0]         cand_size,
   input  logic [SIZE_WIDTH-1:0]         best_size,
   input  logic [fpba_pkg::AMOUNT_W-1:0] amount,
   input  fpba_pkg::cmp_ctl_type         ctl,
   output logic                          better
);
   import fpba_pkg::*;

   localparam int CMP_W = (SIZE_WIDTH > AMOUNT_W) ? SIZE_WIDTH : AMOUNT_W;

   logic [CMP_W-1:0] cand_ext;
   logic [CMP_W-1:0] amount_ext;
   logic             qualify;
   logic             wins;

   assign cand_ext   = CMP_W'(cand_size);
   assign amount_ext = CMP_W'(amount);

   // Zero-size and taken blocks never qualify
   assign qualify = !ctl.taken && (cand_size != '0) && (cand_ext >= amount_ext);

   always_comb begin
      unique case (ctl.policy)
         POLICY_BEST:  wins = cand_size < best_size;
         POLICY_WORST: wins = cand_size > best_size;
         default:      wins = 1'b0;
      endcase
   end

   assign better = qualify && (!ctl.found || wins);

endmodule

// File: hdl/fit_policy_block_allocator_unit.sv
// ---------------------------------------------------------------------------
// Fit policy block allocator
// Fixed-partition allocator with first, best and worst fit selection.
// ---------------------------------------------------------------------------
// A load beat leaves busy low and produces no result; a load into a full
// table is dropped. An allocate beat holds busy high while the size table
// is scanned: it is read one entry a cycle through its single registered
// read port, and each entry goes through the one shared fit comparator. The
// result appears on the rsp_ ports for one cycle, marked by rsp_valid, in the
// first cycle that busy is low again; it cannot be held off, and a new beat
// may start in that same cycle.
// The policy register may be written whenever the block is idle.
module fit_policy_block_allocator_unit #(
   parameter int MAX_BLOCKS = 16,
   parameter int SIZE_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_type,
   input  logic [fpba_pkg::AMOUNT_W-1:0]  req_amount,
   output logic                           rsp_valid,
   output logic                           rsp_granted,
   output logic [fpba_pkg::BLK_IDX_W-1:0] rsp_block_index,
   output logic [fpba_pkg::REQ_NUM_W-1:0] rsp_request_number,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  fpba_pkg::policy_type           csr_data
);
   import fpba_pkg::*;

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic                  state_ff, state_in;
   policy_type            policy_ff;
   logic [CNT_W-1:0]      loaded_ff, loaded_in;
   logic [REQ_NUM_W-1:0]  req_cnt_ff, req_cnt_in;
   logic [MAX_BLOCKS-1:0] taken_ff, taken_in;
   logic [CNT_W-1:0]      issue_ff, issue_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                  rd_taken_ff, rd_taken_in;
   logic [AMOUNT_W-1:0]   amount_ff, amount_in;
   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      pick_ff, pick_in;
   logic [SIZE_WIDTH-1:0] best_ff, best_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_granted_ff, rsp_granted_in;
   logic [BLK_IDX_W-1:0]  rsp_index_ff, rsp_index_in;

   logic                  accept;
   logic                  table_full;
   logic                  wr_en;
   logic [SIZE_WIDTH-1:0] rd_size;
   logic [IDX_W-1:0]      rd_addr;
   logic                  better;
   cmp_ctl_type           cmp_ctl;
   logic [IDX_W+BLK_IDX_W-1:0] pick_ext;

   assign busy       = (state_ff == ST_SCAN);
   assign accept     = start && !busy;
   assign table_full = (loaded_ff >= CNT_W'(MAX_BLOCKS));
   assign wr_en      = accept && (req_type == REQ_LOAD) && !table_full;
   assign rd_addr    = issue_ff[IDX_W-1:0];
   assign csr_ready  = 1'b1;
   assign pick_ext   = {{BLK_IDX_W{1'b0}}, pick_ff};

   fpba_size_ram #(
      .DEPTH  (MAX_BLOCKS),
      .WIDTH  (SIZE_WIDTH),
      .ADDR_W (IDX_W)
   ) u_size_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (loaded_ff[IDX_W-1:0]),
      .wr_data (SIZE_WIDTH'(req_amount)),
      .rd_addr (rd_addr),
      .rd_data (rd_size)
   );

   assign cmp_ctl.found  = found_ff;
   assign cmp_ctl.taken  = rd_taken_ff;
   assign cmp_ctl.policy = policy_ff;

   fpba_fit_cmp #(
      .SIZE_WIDTH (SIZE_WIDTH)
   ) u_fit_cmp (
      .cand_size (rd_size),
      .best_size (best_ff),
      .amount    (amount_ff),
      .ctl       (cmp_ctl),
      .better    (better)
   );

   always_comb begin
      state_in       = state_ff;
      loaded_in      = loaded_ff;
      req_cnt_in     = req_cnt_ff;
      taken_in       = taken_ff;
      issue_in       = issue_ff;
      rd_vld_in      = 1'b0;
      rd_idx_in      = rd_idx_ff;
      rd_taken_in    = rd_taken_ff;
      amount_in      = amount_ff;
      found_in       = found_ff;
      pick_in        = pick_ff;
      best_in        = best_ff;
      rsp_valid_in   = 1'b0;
      rsp_granted_in = rsp_granted_ff;
      rsp_index_in   = rsp_index_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_LOAD) begin
                  if (!table_full) begin
                     taken_in[loaded_ff[IDX_W-1:0]] = 1'b0;
                     loaded_in = loaded_ff + CNT_W'(1);
                  end
               end else begin
                  req_cnt_in = req_cnt_ff + REQ_NUM_W'(1);
                  amount_in  = req_amount;
                  issue_in   = '0;
                  found_in   = 1'b0;
                  pick_in    = '0;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // Issue one table read per cycle
            if (issue_ff < loaded_ff) begin
               rd_vld_in   = 1'b1;
               rd_idx_in   = rd_addr;
               rd_taken_in = taken_ff[rd_addr];
               issue_in    = issue_ff + CNT_W'(1);
            end
            if (rd_vld_ff) begin
               if (better) begin
                  found_in = 1'b1;
                  pick_in  = rd_idx_ff;
                  best_in  = rd_size;
               end
            end else if (issue_ff >= loaded_ff) begin
               // Pipeline drained: report and mark the pick taken
               rsp_valid_in   = 1'b1;
               rsp_granted_in = found_ff;
               rsp_index_in   = found_ff ? pick_ext[BLK_IDX_W-1:0] : '0;
               if (found_ff) begin
                  taken_in[pick_ff] = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         policy_ff    <= POLICY_FIRST;
         loaded_ff    <= '0;
         req_cnt_ff   <= '0;
         taken_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         req_cnt_ff   <= req_cnt_in;
         taken_ff     <= taken_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            policy_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      issue_ff       <= issue_in;
      rd_idx_ff      <= rd_idx_in;
      rd_taken_ff    <= rd_taken_in;
      amount_ff      <= amount_in;
      found_ff       <= found_in;
      pick_ff        <= pick_in;
      best_ff        <= best_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_index_ff   <= rsp_index_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted        = rsp_granted_ff;
   assign rsp_block_index    = rsp_index_ff;
   assign rsp_request_number = req_cnt_ff;

`ifndef ASSERT_OFF
   a_rsp_after_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result beat without a preceding scan");

   a_alloc_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_type == REQ_ALLOC)) |=> busy)
      else $error("allocate beat did not start a scan");

   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_type == REQ_LOAD)) |=> (!busy && !rsp_valid))
      else $error("load beat produced activity");

   a_loaded_bound: assert property (@(posedge clock) disable iff (reset)
      loaded_ff <= CNT_W'(MAX_BLOCKS))
      else $error("loaded block count exceeds table depth");
`endif

endmodule
